// ----- rtl/mtd_pkg.sv -----
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared constants and types of the affine matrix decomposition pipeline.
// ----------------------------------------------------------------------------
package mtd_pkg;

    // One root bit per square root stage, one quotient bit per divider stage
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    // Register stages from input accept to the result register
    localparam int PIPE_LAT = 7 + 2 * SQRT_STAGES + 2 * DIV_STAGES;

    // 1.0 in Q2.30, 1.0 in Q1.14
    localparam logic signed [33:0] RONE = 34'sd1073741824;
    localparam logic [15:0]        QONE = 16'd16384;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    // Carried alongside the column length roots
    typedef struct packed {
        logic [8:0][31:0] mag;
        logic [8:0]       sgn;
        logic [2:0][31:0] mv;
    } t_sa;

    // Carried alongside the normalizing dividers
    typedef struct packed {
        logic [2:0][31:0] mv;
        logic [2:0][30:0] size;
        logic             degen;
        logic [8:0]       sgn;
    } t_sb;

    // Carried to the result stage
    typedef struct packed {
        logic [2:0][31:0] mv;
        logic [2:0][30:0] size;
        logic             degen;
    } t_sc;

    // Off-lead numerators, in quaternion order with the lead removed
    typedef struct packed {
        logic [2:0][32:0] num;
        t_branch          br;
    } t_sn;

    // Flags alongside the quaternion dividers
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] ovf;
        logic       zero;
        logic [30:0] lead;
        t_branch    br;
    } t_sf;

    typedef struct packed {
        logic [2:0][31:0] mv;
        logic [2:0][30:0] size;
        logic [3:0][15:0] quat;
        logic             degen;
    } t_res;

endpackage

// ----- rtl/mtd_if.sv -----
// ----------------------------------------------------------------------------
// mtd_in_if / mtd_out_if
// Valid/ready channels of the matrix decomposition block.
// ----------------------------------------------------------------------------
interface mtd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] c0_r0;
    logic signed [31:0] c0_r1;
    logic signed [31:0] c0_r2;
    logic signed [31:0] c1_r0;
    logic signed [31:0] c1_r1;
    logic signed [31:0] c1_r2;
    logic signed [31:0] c2_r0;
    logic signed [31:0] c2_r1;
    logic signed [31:0] c2_r2;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;

    modport source (
        output valid, c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2,
               c2_r0, c2_r1, c2_r2, move_x, move_y, move_z,
        input  ready
    );
    modport sink (
        input  valid, c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2,
               c2_r0, c2_r1, c2_r2, move_x, move_y, move_z,
        output ready
    );
endinterface

interface mtd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_move_x;
    logic signed [31:0] out_move_y;
    logic signed [31:0] out_move_z;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [30:0]        size_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;

    modport source (
        output valid, out_move_x, out_move_y, out_move_z, size_x, size_y, size_z,
               quat_w, quat_x, quat_y, quat_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, out_move_x, out_move_y, out_move_z, size_x, size_y, size_z,
               quat_w, quat_x, quat_y, quat_z, degenerate,
        output ready
    );
endinterface

// ----- rtl/mtd_sqrt.sv -----
// ----------------------------------------------------------------------------
// mtd_sqrt
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module mtd_sqrt
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];
    logic [63:0] r_rad  [SQRT_STAGES];
    logic [33:0] n_rem  [SQRT_STAGES];
    logic [31:0] n_root [SQRT_STAGES];
    logic [63:0] n_rad  [SQRT_STAGES];
    logic [33:0] p_rem  [SQRT_STAGES];
    logic [31:0] p_root [SQRT_STAGES];
    logic [63:0] p_rad  [SQRT_STAGES];

    always_comb begin
        p_rem[0]  = '0;
        p_root[0] = '0;
        p_rad[0]  = i_rad;
        for (int k = 1; k < SQRT_STAGES; k++) begin
            p_rem[k]  = r_rem[k-1];
            p_root[k] = r_root[k-1];
            p_rad[k]  = r_rad[k-1];
        end
    end

    always_comb begin
        logic [35:0] cur;
        logic [35:0] trial;
        logic [35:0] diff;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            cur   = {p_rem[k], p_rad[k][63:62]};
            trial = {2'b00, p_root[k], 2'b01};
            diff  = cur - trial;
            if (cur >= trial) begin
                n_rem[k]  = diff[33:0];
                n_root[k] = {p_root[k][30:0], 1'b1};
            end else begin
                n_rem[k]  = cur[33:0];
                n_root[k] = {p_root[k][30:0], 1'b0};
            end
            n_rad[k] = {p_rad[k][61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// ----- rtl/mtd_div.sv -----
// ----------------------------------------------------------------------------
// mtd_div
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per stage. The quotient must fit in 32 bits.
// ----------------------------------------------------------------------------
module mtd_div
    import mtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);

    logic [31:0] r_part [DIV_STAGES];
    logic [31:0] r_low  [DIV_STAGES];
    logic [31:0] r_den  [DIV_STAGES];
    logic [31:0] r_quo  [DIV_STAGES];
    logic [31:0] n_part [DIV_STAGES];
    logic [31:0] n_low  [DIV_STAGES];
    logic [31:0] n_quo  [DIV_STAGES];
    logic [31:0] p_part [DIV_STAGES];
    logic [31:0] p_low  [DIV_STAGES];
    logic [31:0] p_den  [DIV_STAGES];
    logic [31:0] p_quo  [DIV_STAGES];

    always_comb begin
        p_part[0] = i_num[63:32];
        p_low[0]  = i_num[31:0];
        p_den[0]  = i_den;
        p_quo[0]  = '0;
        for (int k = 1; k < DIV_STAGES; k++) begin
            p_part[k] = r_part[k-1];
            p_low[k]  = r_low[k-1];
            p_den[k]  = r_den[k-1];
            p_quo[k]  = r_quo[k-1];
        end
    end

    always_comb begin
        logic [32:0] sh;
        logic [32:0] diff;
        for (int k = 0; k < DIV_STAGES; k++) begin
            sh   = {p_part[k], p_low[k][31]};
            diff = sh - {1'b0, p_den[k]};
            if (sh >= {1'b0, p_den[k]}) begin
                n_part[k] = diff[31:0];
                n_quo[k]  = {p_quo[k][30:0], 1'b1};
            end else begin
                n_part[k] = sh[31:0];
                n_quo[k]  = {p_quo[k][30:0], 1'b0};
            end
            n_low[k] = {p_low[k][30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_part[k] <= n_part[k];
                r_low[k]  <= n_low[k];
                r_den[k]  <= p_den[k];
                r_quo[k]  <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ----- rtl/matrix_trs_decompose.sv -----
// ----------------------------------------------------------------------------
// matrix_trs_decompose
// Splits an affine matrix into translation, per-column size and rotation
// quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one matrix per item: the 3x3 linear part by columns and the
//   translation, signed Q15.16. o_out carries one result per item: the
//   translation unchanged, the three column lengths (saturating) and the
//   rotation quaternion in Q1.14, or the identity with degenerate set when a
//   column has zero length.
//   Throughput is one item per cycle while the output queue is not full. An
//   item passes two 32-stage square roots and two 32-stage divider banks in
//   series, plus the squaring, trace, branch and rounding stages.
//   A two-entry output queue sits behind the pipeline; i_in.ready comes from
//   its fill count alone. When the receiver stalls, the queue fills and the
//   whole pipeline freezes in place with ready low; nothing is lost.
//   Reset clears the valid bits and the queue; ready is high the cycle after.
// ----------------------------------------------------------------------------
module matrix_trs_decompose
    import mtd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtd_in_if.sink     i_in,
    mtd_out_if.source  o_out
);

    localparam int DLA_LEN = SQRT_STAGES + 2;
    localparam int DLB_LEN = DIV_STAGES;
    localparam int DLC_LEN = SQRT_STAGES + DIV_STAGES + 4;
    localparam int DLN_LEN = SQRT_STAGES + 1;
    localparam int DLF_LEN = DIV_STAGES + 1;

    function automatic logic [15:0] f_q14(input logic [32:0] mag, input logic neg,
                                          input logic ovf);
        logic [33:0] sum;
        logic [17:0] rr;
        logic [15:0] res;
        sum = {1'b0, mag} + 34'd32768;
        rr  = sum[33:16];
        if (neg) begin
            if (ovf || rr > 18'd32768) res = 16'h8000;
            else                       res = 16'(~rr[15:0] + 16'd1);
        end else begin
            if (ovf || rr > 18'd32767) res = 16'h7FFF;
            else                       res = rr[15:0];
        end
        return res;
    endfunction

    logic                 en;
    logic                 in_fire;
    logic [PIPE_LAT-1:0]  r_vld;

    // squaring and column sums
    logic [8:0][31:0]     in_e;
    logic [8:0][31:0]     in_mag;
    logic [8:0][63:0]     sq;
    logic [63:0]          r_sq  [9];
    logic [63:0]          r_sum [3];
    t_sa                  sa_in;
    t_sa                  r_dla [DLA_LEN];
    logic [2:0][31:0]     len;

    // normalization
    t_sa                  sa;
    t_sb                  sb_in;
    t_sb                  r_dlb [DLB_LEN];
    t_sb                  sb;
    logic [8:0][63:0]     rnum;
    logic [8:0][31:0]     rquo;
    logic signed [31:0]   r_rx  [9];
    t_sc                  r_dlc [DLC_LEN];

    // trace and branch
    logic signed [33:0]   r_tr;
    logic                 r_gt0;
    logic                 r_gt1;
    logic signed [31:0]   r_dg  [3];
    logic signed [32:0]   r_pm  [6];
    logic signed [33:0]   v;
    t_sn                  sn_in;
    logic [63:0]          srad;
    logic [63:0]          r_srad;
    t_sn                  r_dln [DLN_LEN];
    logic [31:0]          s;

    // quaternion division
    t_sn                  sn;
    logic [2:0][32:0]     nmag;
    t_sf                  sf_in;
    logic [63:0]          r_qnum [3];
    logic [31:0]          r_qden;
    t_sf                  r_dlf [DLF_LEN];
    logic [2:0][31:0]     qquo;

    // result and output queue
    t_sf                  sf;
    t_sc                  sc;
    t_res                 res;
    t_res                 r_res;
    t_res                 r_q [2];
    logic                 r_wr;
    logic                 r_rd;
    logic [1:0]           r_cnt;
    logic                 push;
    logic                 pop;
    logic [1:0]           jj;

    assign en       = (r_cnt != 2'd2);
    assign in_fire  = i_in.valid & en;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], in_fire};
        end
    end

    // ---------------- squares of the elements ----------------
    assign in_e[0] = i_in.c0_r0;
    assign in_e[1] = i_in.c0_r1;
    assign in_e[2] = i_in.c0_r2;
    assign in_e[3] = i_in.c1_r0;
    assign in_e[4] = i_in.c1_r1;
    assign in_e[5] = i_in.c1_r2;
    assign in_e[6] = i_in.c2_r0;
    assign in_e[7] = i_in.c2_r1;
    assign in_e[8] = i_in.c2_r2;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            in_mag[k] = in_e[k][31] ? 32'(-in_e[k]) : in_e[k];
            sq[k]     = in_mag[k] * in_mag[k];
        end
        sa_in.mag = in_mag;
        for (int k = 0; k < 9; k++) sa_in.sgn[k] = in_e[k][31];
        sa_in.mv[0] = i_in.move_x;
        sa_in.mv[1] = i_in.move_y;
        sa_in.mv[2] = i_in.move_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) r_sq[k] <= sq[k];
            for (int c = 0; c < 3; c++) r_sum[c] <= r_sq[3*c] + r_sq[3*c+1] + r_sq[3*c+2];
            r_dla[0] <= sa_in;
            for (int k = 1; k < DLA_LEN; k++) r_dla[k] <= r_dla[k-1];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_len
        mtd_sqrt u_len (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  (r_sum[c]),
            .o_root (len[c])
        );
    end

    // ---------------- normalize by column length ----------------
    assign sa = r_dla[DLA_LEN-1];

    always_comb begin
        for (int k = 0; k < 9; k++) rnum[k] = {2'b00, sa.mag[k], 30'd0};
        sb_in.mv    = sa.mv;
        sb_in.sgn   = sa.sgn;
        sb_in.degen = (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
        for (int c = 0; c < 3; c++) begin
            sb_in.size[c] = len[c][31] ? 31'h7FFFFFFF : len[c][30:0];
        end
    end

    for (genvar g = 0; g < 9; g++) begin : g_rdiv
        mtd_div u_rdiv (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (rnum[g]),
            .i_den  (len[g/3]),
            .o_quo  (rquo[g])
        );
    end

    assign sb = r_dlb[DLB_LEN-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dlb[0] <= sb_in;
            for (int k = 1; k < DLB_LEN; k++) r_dlb[k] <= r_dlb[k-1];
            for (int k = 0; k < 9; k++) r_rx[k] <= sb.sgn[k] ? 32'(-rquo[k]) : rquo[k];
            r_dlc[0] <= '{mv: sb.mv, size: sb.size, degen: sb.degen};
            for (int k = 1; k < DLC_LEN; k++) r_dlc[k] <= r_dlc[k-1];
        end
    end

    // ---------------- trace, diagonal compares, pair terms ----------------
    // r_rx index is column * 3 + row
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tr  <= 34'(r_rx[0]) + 34'(r_rx[4]) + 34'(r_rx[8]);
            r_gt0 <= (r_rx[0] > r_rx[4]) && (r_rx[0] > r_rx[8]);
            r_gt1 <= (r_rx[4] > r_rx[8]);
            r_dg[0] <= r_rx[0];
            r_dg[1] <= r_rx[4];
            r_dg[2] <= r_rx[8];
            r_pm[0] <= 33'(r_rx[5]) - 33'(r_rx[7]);
            r_pm[1] <= 33'(r_rx[6]) - 33'(r_rx[2]);
            r_pm[2] <= 33'(r_rx[1]) - 33'(r_rx[3]);
            r_pm[3] <= 33'(r_rx[3]) + 33'(r_rx[1]);
            r_pm[4] <= 33'(r_rx[6]) + 33'(r_rx[2]);
            r_pm[5] <= 33'(r_rx[7]) + 33'(r_rx[5]);
        end
    end

    always_comb begin
        if (r_tr > 34'sd0) begin
            sn_in.br  = BR_TRACE;
            v         = RONE + r_tr;
            sn_in.num = {r_pm[2], r_pm[1], r_pm[0]};
        end else if (r_gt0) begin
            sn_in.br  = BR_X;
            v         = RONE + 34'(r_dg[0]) - 34'(r_dg[1]) - 34'(r_dg[2]);
            sn_in.num = {r_pm[4], r_pm[3], r_pm[0]};
        end else if (r_gt1) begin
            sn_in.br  = BR_Y;
            v         = RONE + 34'(r_dg[1]) - 34'(r_dg[0]) - 34'(r_dg[2]);
            sn_in.num = {r_pm[5], r_pm[3], r_pm[1]};
        end else begin
            sn_in.br  = BR_Z;
            v         = RONE + 34'(r_dg[2]) - 34'(r_dg[0]) - 34'(r_dg[1]);
            sn_in.num = {r_pm[5], r_pm[4], r_pm[2]};
        end
        // non-orthogonal input can drive the branch value negative
        srad = (v > 34'sd0) ? {1'b0, v[32:0], 30'd0} : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srad   <= srad;
            r_dln[0] <= sn_in;
            for (int k = 1; k < DLN_LEN; k++) r_dln[k] <= r_dln[k-1];
        end
    end

    mtd_sqrt u_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_srad),
        .o_root (s)
    );

    // ---------------- quaternion division setup ----------------
    assign sn = r_dln[DLN_LEN-1];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            nmag[j]      = sn.num[j][32] ? 33'(-sn.num[j]) : sn.num[j];
            sf_in.neg[j] = sn.num[j][32];
            // quotient would not fit 32 bits: saturates anyway
            sf_in.ovf[j] = {3'b000, nmag[j][31:0]} >= {s, 3'b000};
        end
        sf_in.zero = (s == '0);
        sf_in.lead = s[31:1];
        sf_in.br   = sn.br;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) r_qnum[j] <= {3'b000, nmag[j][31:0], 29'd0};
            r_qden   <= s;
            r_dlf[0] <= sf_in;
            for (int k = 1; k < DLF_LEN; k++) r_dlf[k] <= r_dlf[k-1];
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_qdiv
        mtd_div u_qdiv (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_qnum[j]),
            .i_den  (r_qden),
            .o_quo  (qquo[j])
        );
    end

    // ---------------- rounding and result ----------------
    assign sf = r_dlf[DLF_LEN-1];
    assign sc = r_dlc[DLC_LEN-1];

    always_comb begin
        res.mv    = sc.mv;
        res.size  = sc.size;
        res.degen = sc.degen;
        jj        = '0;
        for (int p = 0; p < 4; p++) begin
            if (p == int'(sf.br)) begin
                res.quat[p] = f_q14({2'b00, sf.lead}, 1'b0, 1'b0);
            end else begin
                jj = (p < int'(sf.br)) ? 2'(p) : 2'(p - 1);
                res.quat[p] = sf.zero ? 16'd0
                            : f_q14({1'b0, qquo[jj]}, sf.neg[jj], sf.ovf[jj]);
            end
        end
        if (sc.degen) begin
            res.quat[0] = QONE;
            res.quat[1] = '0;
            res.quat[2] = '0;
            res.quat[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_res <= res;
    end

    // ---------------- output queue ----------------
    assign push = en & r_vld[PIPE_LAT-1];
    assign pop  = o_out.valid & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_move_x = r_q[r_rd].mv[0];
    assign o_out.out_move_y = r_q[r_rd].mv[1];
    assign o_out.out_move_z = r_q[r_rd].mv[2];
    assign o_out.size_x     = r_q[r_rd].size[0];
    assign o_out.size_y     = r_q[r_rd].size[1];
    assign o_out.size_z     = r_q[r_rd].size[2];
    assign o_out.quat_w     = r_q[r_rd].quat[0];
    assign o_out.quat_x     = r_q[r_rd].quat[1];
    assign o_out.quat_y     = r_q[r_rd].quat[2];
    assign o_out.quat_z     = r_q[r_rd].quat[3];
    assign o_out.degenerate = r_q[r_rd].degen;

endmodule

// ----- rtl/mtd_checker.sv -----
// ----------------------------------------------------------------------------
// mtd_checker
// Port-level checks of the matrix decomposition block, bound to its top.
// ----------------------------------------------------------------------------
module mtd_checker
    import mtd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_ready,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [253:0] i_out_data,
    input  logic [30:0]  i_size_x,
    input  logic [30:0]  i_size_y,
    input  logic [30:0]  i_size_z,
    input  logic [15:0]  i_quat_w,
    input  logic [15:0]  i_quat_x,
    input  logic [15:0]  i_quat_y,
    input  logic [15:0]  i_quat_z,
    input  logic         i_degenerate
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed or dropped");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |->
            i_quat_w == QONE && i_quat_x == 16'd0 && i_quat_y == 16'd0 && i_quat_z == 16'd0)
        else $error("degenerate item without identity quaternion");

    a_degen_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_degenerate == (i_size_x == '0 || i_size_y == '0 || i_size_z == '0))
        else $error("degenerate flag disagrees with column sizes");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input held off with no result waiting");

endmodule

bind matrix_trs_decompose mtd_checker u_mtd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_data   ({o_out.out_move_x, o_out.out_move_y, o_out.out_move_z,
                    o_out.size_x, o_out.size_y, o_out.size_z,
                    o_out.quat_w, o_out.quat_x, o_out.quat_y, o_out.quat_z,
                    o_out.degenerate}),
    .i_size_x     (o_out.size_x),
    .i_size_y     (o_out.size_y),
    .i_size_z     (o_out.size_z),
    .i_quat_w     (o_out.quat_w),
    .i_quat_x     (o_out.quat_x),
    .i_quat_y     (o_out.quat_y),
    .i_quat_z     (o_out.quat_z),
    .i_degenerate (o_out.degenerate)
);
